// ===== src/bilinear_grid_interpolator_macros.svh =====
// assertion helpers for the bilinear grid interpolator
`ifndef BILINEAR_GRID_INTERPOLATOR_MACROS_SVH
`define BILINEAR_GRID_INTERPOLATOR_MACROS_SVH

// checked only while out of reset
`define BGI_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked at every edge, reset included
`define BGI_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== src/bgi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package bgi_pkg;

   localparam int MAX_X_POINTS_DEF = 64;
   localparam int MAX_Y_POINTS_DEF = 64;

   // input item kinds
   localparam logic MODE_WRITE = 1'b0;
   localparam logic MODE_EVAL  = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_OUT_OF_RANGE = 2'd1;
   localparam logic [1:0] STATUS_NO_GRID      = 2'd2;

   // register indexes
   localparam logic [2:0] REG_X_MIN    = 3'd0;
   localparam logic [2:0] REG_X_MAX    = 3'd1;
   localparam logic [2:0] REG_X_SCALE  = 3'd2;
   localparam logic [2:0] REG_Y_MIN    = 3'd3;
   localparam logic [2:0] REG_Y_MAX    = 3'd4;
   localparam logic [2:0] REG_Y_SCALE  = 3'd5;
   localparam logic [2:0] REG_X_POINTS = 3'd6;
   localparam logic [2:0] REG_Y_POINTS = 3'd7;

   localparam int REQ_DATA_W = 112;
   localparam int RSP_DATA_W = 32;

endpackage

`default_nettype wire

// ===== src/bgi_sample_store.sv =====
`timescale 1ns / 1ps
`default_nettype none

// four banks split by column and row parity, so the four corners of a cell
// always fall in different banks
module bgi_sample_store #(
   parameter int MAX_X_POINTS = 64,
   parameter int MAX_Y_POINTS = 64,
   parameter int XCW = $clog2(MAX_X_POINTS),
   parameter int YCW = $clog2(MAX_Y_POINTS)
) (
   input  wire logic            clock,
   input  wire logic            wr_en,
   input  wire logic [XCW-1:0]  wr_x,
   input  wire logic [YCW-1:0]  wr_y,
   input  wire logic [31:0]     wr_data,
   input  wire logic            rd_en,
   input  wire logic [XCW-1:0]  rd_x,
   input  wire logic [YCW-1:0]  rd_y,
   output logic [31:0]          n00,
   output logic [31:0]          n01,
   output logic [31:0]          n10,
   output logic [31:0]          n11
);

   localparam int XH    = (MAX_X_POINTS + 1) / 2;
   localparam int YH    = (MAX_Y_POINTS + 1) / 2;
   localparam int DEPTH = XH * YH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [31:0] rdata_ff [4];
   logic        par_x_ff;
   logic        par_y_ff;

   logic [AW-1:0] wr_addr;
   assign wr_addr = AW'((32'(wr_x) >> 1) * YH + (32'(wr_y) >> 1));

   for (genvar p = 0; p < 2; p++) begin : g_col
      for (genvar q = 0; q < 2; q++) begin : g_row
         logic [31:0]   mem [DEPTH];
         logic [XCW-1:0] rx;
         logic [YCW-1:0] ry;
         logic [AW-1:0]  rd_addr;
         logic           bank_we;

         assign rx      = (rd_x[0] == 1'(p)) ? rd_x : rd_x + XCW'(1);
         assign ry      = (rd_y[0] == 1'(q)) ? rd_y : rd_y + YCW'(1);
         assign rd_addr = AW'((32'(rx) >> 1) * YH + (32'(ry) >> 1));
         assign bank_we = wr_en && (wr_x[0] == 1'(p)) && (wr_y[0] == 1'(q));

         always_ff @(posedge clock) begin
            if (bank_we) begin
               mem[wr_addr] <= wr_data;
            end
            if (rd_en) begin
               rdata_ff[p * 2 + q] <= mem[rd_addr];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         par_x_ff <= rd_x[0];
         par_y_ff <= rd_y[0];
      end
   end

   assign n00 = rdata_ff[{par_x_ff, par_y_ff}];
   assign n01 = rdata_ff[{par_x_ff, ~par_y_ff}];
   assign n10 = rdata_ff[{~par_x_ff, par_y_ff}];
   assign n11 = rdata_ff[{~par_x_ff, ~par_y_ff}];

endmodule

`default_nettype wire

// ===== src/bilinear_grid_interpolator.sv =====
`timescale 1ns / 1ps
`default_nettype none

// bilinear interpolator over a uniform grid of signed q16.16 samples. a word
// on req_ is either a sample write (req_tuser 0) or a point evaluation
// (req_tuser 1); every word gives exactly one word on rsp_, in order. writes
// answer value 0 / status ok; writing the far corner (x_points-1, y_points-1)
// marks the grid ready. an evaluation outside [min, max] on either axis
// answers status 1, one before the grid is ready answers status 2, both with
// value 0. the block is a nine-stage pipeline: one word enters per cycle
// while req_tready is high, and results are held back only by rsp_tready.
// each stage advances on its own, so bubbles
// close up and req_tready drops only when all nine stages are full and the
// output is stalled. sample writes and corner reads meet the banked store in
// the same stage, which keeps them in word order. samples never written read
// as garbage. csr writes are taken every cycle and must only be issued while
// the pipeline is empty.
module bilinear_grid_interpolator #(
   parameter int MAX_X_POINTS = bgi_pkg::MAX_X_POINTS_DEF,
   parameter int MAX_Y_POINTS = bgi_pkg::MAX_Y_POINTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // request side
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // x_index[5:0] y_index[11:6] grid_value[43:12] x_coord[75:44] y_coord[107:76]
   input  wire logic [bgi_pkg::REQ_DATA_W-1:0]  req_tdata,
   // mode[0]
   input  wire logic                            req_tuser,
   // result side
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // value[31:0]
   output logic [bgi_pkg::RSP_DATA_W-1:0]       rsp_tdata,
   // status[1:0]
   output logic [1:0]                           rsp_tuser,
   // register writes
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [2:0]                      csr_index,
   input  wire logic [31:0]                     csr_data
);

   import bgi_pkg::*;

   localparam int NST = 9;
   localparam int XCW = $clog2(MAX_X_POINTS);
   localparam int YCW = $clog2(MAX_Y_POINTS);
   localparam int NXW = $clog2(MAX_X_POINTS + 1);
   localparam int NYW = $clog2(MAX_Y_POINTS + 1);

   // ---------------------------------------------------------------- registers
   logic signed [31:0] x_min_ff, x_max_ff, y_min_ff, y_max_ff;
   logic [31:0]        x_scale_ff, y_scale_ff;
   logic [6:0]         x_points_ff, y_points_ff;
   logic               grid_ready_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_min_ff    <= '0;
         x_max_ff    <= 32'sd65536;
         x_scale_ff  <= 32'd65536;
         y_min_ff    <= '0;
         y_max_ff    <= 32'sd65536;
         y_scale_ff  <= 32'd65536;
         x_points_ff <= 7'd2;
         y_points_ff <= 7'd2;
      end else if (csr_valid) begin
         case (csr_index)
            REG_X_MIN:    x_min_ff    <= csr_data;
            REG_X_MAX:    x_max_ff    <= csr_data;
            REG_X_SCALE:  x_scale_ff  <= csr_data;
            REG_Y_MIN:    y_min_ff    <= csr_data;
            REG_Y_MAX:    y_max_ff    <= csr_data;
            REG_Y_SCALE:  y_scale_ff  <= csr_data;
            REG_X_POINTS: x_points_ff <= csr_data[6:0];
            REG_Y_POINTS: y_points_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   // points in use, clamped into [2, max]
   logic [NXW-1:0] nx;
   logic [NYW-1:0] ny;

   always_comb begin
      if (x_points_ff < 7'd2) begin
         nx = NXW'(2);
      end else if (32'(x_points_ff) > 32'(MAX_X_POINTS)) begin
         nx = NXW'(MAX_X_POINTS);
      end else begin
         nx = NXW'(x_points_ff);
      end
      if (y_points_ff < 7'd2) begin
         ny = NYW'(2);
      end else if (32'(y_points_ff) > 32'(MAX_Y_POINTS)) begin
         ny = NYW'(MAX_Y_POINTS);
      end else begin
         ny = NYW'(y_points_ff);
      end
   end

   // ---------------------------------------------------------------- flow control
   logic [NST:1]   vld_ff, vld_in;
   logic [NST+1:1] en;

   always_comb begin
      en[NST+1] = rsp_tready;
      for (int k = NST; k >= 1; k--) begin
         en[k] = !vld_ff[k] || en[k+1];
      end
      vld_in = vld_ff;
      if (en[1]) begin
         vld_in[1] = req_tvalid;
      end
      for (int k = 2; k <= NST; k++) begin
         if (en[k]) begin
            vld_in[k] = vld_ff[k-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign req_tready = en[1];

   // ---------------------------------------------------------------- stage 1
   // unpack, limit check, offsets from the lower limits, write decode
   logic [5:0]         in_xi, in_yi;
   logic signed [31:0] in_val, in_x, in_y;
   logic [31:0]        off_x, off_y;
   logic               in_we, in_last, in_oor;

   assign in_xi  = req_tdata[5:0];
   assign in_yi  = req_tdata[11:6];
   assign in_val = req_tdata[43:12];
   assign in_x   = req_tdata[75:44];
   assign in_y   = req_tdata[107:76];
   // an in-range offset is never negative and fits 32 bits unsigned
   assign off_x  = in_x - x_min_ff;
   assign off_y  = in_y - y_min_ff;
   assign in_oor = (in_x > x_max_ff) || (in_x < x_min_ff)
                || (in_y > y_max_ff) || (in_y < y_min_ff);
   assign in_we  = (req_tuser == MODE_WRITE)
                && (32'(in_xi) < 32'(nx)) && (32'(in_yi) < 32'(ny));
   assign in_last = (32'(in_xi) == 32'(nx) - 32'd1) && (32'(in_yi) == 32'(ny) - 32'd1);

   logic           s1_mode_ff, s1_we_ff, s1_last_ff, s1_oor_ff;
   logic [XCW-1:0] s1_xi_ff;
   logic [YCW-1:0] s1_yi_ff;
   logic [31:0]    s1_val_ff, s1_offx_ff, s1_offy_ff;

   always_ff @(posedge clock) begin
      if (en[1]) begin
         s1_mode_ff <= req_tuser;
         s1_we_ff   <= in_we;
         s1_last_ff <= in_last;
         s1_oor_ff  <= in_oor;
         s1_xi_ff   <= XCW'(in_xi);
         s1_yi_ff   <= YCW'(in_yi);
         s1_val_ff  <= in_val;
         s1_offx_ff <= off_x;
         s1_offy_ff <= off_y;
      end
   end

   // ---------------------------------------------------------------- stage 2
   // grid position q32.32 = offset * scale
   logic           s2_mode_ff, s2_we_ff, s2_last_ff, s2_oor_ff;
   logic [XCW-1:0] s2_xi_ff;
   logic [YCW-1:0] s2_yi_ff;
   logic [31:0]    s2_val_ff;
   logic [63:0]    s2_ux_ff, s2_uy_ff;

   always_ff @(posedge clock) begin
      if (en[2]) begin
         s2_mode_ff <= s1_mode_ff;
         s2_we_ff   <= s1_we_ff;
         s2_last_ff <= s1_last_ff;
         s2_oor_ff  <= s1_oor_ff;
         s2_xi_ff   <= s1_xi_ff;
         s2_yi_ff   <= s1_yi_ff;
         s2_val_ff  <= s1_val_ff;
         s2_ux_ff   <= 64'(s1_offx_ff) * 64'(x_scale_ff);
         s2_uy_ff   <= 64'(s1_offy_ff) * 64'(y_scale_ff);
      end
   end

   // ---------------------------------------------------------------- stage 3
   // cell and fraction; past the last cell clamps to it with fraction one
   logic [XCW-1:0] cell_x;
   logic [YCW-1:0] cell_y;
   logic [16:0]    frac_x, frac_y;

   always_comb begin
      if (s2_ux_ff[63:32] >= 32'(nx) - 32'd1) begin
         cell_x = XCW'(nx - NXW'(2));
         frac_x = 17'h10000;
      end else begin
         cell_x = s2_ux_ff[32 +: XCW];
         frac_x = {1'b0, s2_ux_ff[31:16]};
      end
      if (s2_uy_ff[63:32] >= 32'(ny) - 32'd1) begin
         cell_y = YCW'(ny - NYW'(2));
         frac_y = 17'h10000;
      end else begin
         cell_y = s2_uy_ff[32 +: YCW];
         frac_y = {1'b0, s2_uy_ff[31:16]};
      end
   end

   logic           s3_mode_ff, s3_we_ff, s3_last_ff, s3_oor_ff;
   logic [XCW-1:0] s3_xi_ff, s3_cx_ff;
   logic [YCW-1:0] s3_yi_ff, s3_cy_ff;
   logic [31:0]    s3_val_ff;
   logic [16:0]    s3_fx_ff, s3_fy_ff;

   always_ff @(posedge clock) begin
      if (en[3]) begin
         s3_mode_ff <= s2_mode_ff;
         s3_we_ff   <= s2_we_ff;
         s3_last_ff <= s2_last_ff;
         s3_oor_ff  <= s2_oor_ff;
         s3_xi_ff   <= s2_xi_ff;
         s3_yi_ff   <= s2_yi_ff;
         s3_val_ff  <= s2_val_ff;
         s3_cx_ff   <= cell_x;
         s3_cy_ff   <= cell_y;
         s3_fx_ff   <= frac_x;
         s3_fy_ff   <= frac_y;
      end
   end

   // ---------------------------------------------------------------- stage 4
   // store access: writes and corner reads happen here, in word order
   logic        st_we, st_re;
   logic [31:0] n00, n01, n10, n11;

   assign st_we = en[4] && vld_ff[3] && s3_we_ff;
   assign st_re = en[4] && vld_ff[3] && (s3_mode_ff == MODE_EVAL);

   bgi_sample_store #(
      .MAX_X_POINTS (MAX_X_POINTS),
      .MAX_Y_POINTS (MAX_Y_POINTS)
   ) u_store (
      .clock   (clock),
      .wr_en   (st_we),
      .wr_x    (s3_xi_ff),
      .wr_y    (s3_yi_ff),
      .wr_data (s3_val_ff),
      .rd_en   (st_re),
      .rd_x    (s3_cx_ff),
      .rd_y    (s3_cy_ff),
      .n00     (n00),
      .n01     (n01),
      .n10     (n10),
      .n11     (n11)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_ready_ff <= 1'b0;
      end else if (st_we && s3_last_ff) begin
         grid_ready_ff <= 1'b1;
      end
   end

   logic [1:0]  s4_status_ff;
   logic        s4_zero_ff;
   logic [16:0] s4_fx_ff, s4_fy_ff;
   logic [1:0]  status_in;

   always_comb begin
      if (s3_oor_ff) begin
         status_in = STATUS_OUT_OF_RANGE;
      end else if (!grid_ready_ff) begin
         status_in = STATUS_NO_GRID;
      end else begin
         status_in = STATUS_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         s4_status_ff <= (s3_mode_ff == MODE_EVAL) ? status_in : STATUS_OK;
         s4_zero_ff   <= (s3_mode_ff == MODE_WRITE) || (status_in != STATUS_OK);
         s4_fx_ff     <= s3_fx_ff;
         s4_fy_ff     <= s3_fy_ff;
      end
   end

   // ---------------------------------------------------------------- stage 5
   // corner differences along y
   logic [1:0]         s5_status_ff;
   logic               s5_zero_ff;
   logic [16:0]        s5_fx_ff, s5_fy_ff;
   logic signed [31:0] s5_a0_ff, s5_a1_ff;
   logic signed [32:0] s5_d0_ff, s5_d1_ff;

   always_ff @(posedge clock) begin
      if (en[5]) begin
         s5_status_ff <= s4_status_ff;
         s5_zero_ff   <= s4_zero_ff;
         s5_fx_ff     <= s4_fx_ff;
         s5_fy_ff     <= s4_fy_ff;
         s5_a0_ff     <= n00;
         s5_a1_ff     <= n10;
         s5_d0_ff     <= 33'($signed(n01)) - 33'($signed(n00));
         s5_d1_ff     <= 33'($signed(n11)) - 33'($signed(n10));
      end
   end

   // ---------------------------------------------------------------- stage 6
   logic [1:0]         s6_status_ff;
   logic               s6_zero_ff;
   logic [16:0]        s6_fx_ff;
   logic signed [31:0] s6_a0_ff, s6_a1_ff;
   logic signed [50:0] s6_p0_ff, s6_p1_ff;

   always_ff @(posedge clock) begin
      if (en[6]) begin
         s6_status_ff <= s5_status_ff;
         s6_zero_ff   <= s5_zero_ff;
         s6_fx_ff     <= s5_fx_ff;
         s6_a0_ff     <= s5_a0_ff;
         s6_a1_ff     <= s5_a1_ff;
         s6_p0_ff     <= s5_d0_ff * $signed({1'b0, s5_fy_ff});
         s6_p1_ff     <= s5_d1_ff * $signed({1'b0, s5_fy_ff});
      end
   end

   // ---------------------------------------------------------------- stage 7
   // column results, round half up
   logic signed [50:0] r0, r1;
   logic signed [34:0] q0, q1;

   assign r0 = s6_p0_ff + 51'sd32768;
   assign r1 = s6_p1_ff + 51'sd32768;
   assign q0 = 35'(r0 >>> 16);
   assign q1 = 35'(r1 >>> 16);

   logic [1:0]         s7_status_ff;
   logic               s7_zero_ff;
   logic [16:0]        s7_fx_ff;
   logic signed [33:0] s7_c0_ff, s7_c1_ff;

   always_ff @(posedge clock) begin
      if (en[7]) begin
         s7_status_ff <= s6_status_ff;
         s7_zero_ff   <= s6_zero_ff;
         s7_fx_ff     <= s6_fx_ff;
         s7_c0_ff     <= 34'(q0 + 35'(s6_a0_ff));
         s7_c1_ff     <= 34'(q1 + 35'(s6_a1_ff));
      end
   end

   // ---------------------------------------------------------------- stage 8
   // difference along x times x fraction
   logic signed [34:0] dc;
   assign dc = 35'(s7_c1_ff) - 35'(s7_c0_ff);

   logic [1:0]         s8_status_ff;
   logic               s8_zero_ff;
   logic signed [33:0] s8_c0_ff;
   logic signed [52:0] s8_p_ff;

   always_ff @(posedge clock) begin
      if (en[8]) begin
         s8_status_ff <= s7_status_ff;
         s8_zero_ff   <= s7_zero_ff;
         s8_c0_ff     <= s7_c0_ff;
         s8_p_ff      <= dc * $signed({1'b0, s7_fx_ff});
      end
   end

   // ---------------------------------------------------------------- stage 9
   // final round, saturate, output register
   logic signed [52:0] rp;
   logic signed [36:0] vsum;
   logic [31:0]        vsat;

   assign rp   = s8_p_ff + 53'sd32768;
   assign vsum = 37'(rp >>> 16) + 37'(s8_c0_ff);

   always_comb begin
      if (vsum > 37'sd2147483647) begin
         vsat = 32'h7fff_ffff;
      end else if (vsum < -37'sd2147483648) begin
         vsat = 32'h8000_0000;
      end else begin
         vsat = vsum[31:0];
      end
   end

   logic [31:0] s9_value_ff;
   logic [1:0]  s9_status_ff;

   always_ff @(posedge clock) begin
      if (en[9]) begin
         s9_value_ff  <= s8_zero_ff ? 32'd0 : vsat;
         s9_status_ff <= s8_status_ff;
      end
   end

   assign rsp_tvalid = vld_ff[NST];
   assign rsp_tdata  = s9_value_ff;
   assign rsp_tuser  = s9_status_ff;

endmodule

`default_nettype wire

// ===== src/bilinear_grid_interpolator_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "bilinear_grid_interpolator_macros.svh"

module bilinear_grid_interpolator_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_tready,
   input wire logic                            rsp_tvalid,
   input wire logic                            rsp_tready,
   input wire logic [bgi_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input wire logic [1:0]                      rsp_tuser
);

   import bgi_pkg::*;

   // a held result word does not change
   `BGI_ASSERT(a_rsp_hold, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser), "result word changed while stalled")

   // an error status always carries a zero value
   `BGI_ASSERT(a_err_zero, rsp_tvalid && rsp_tuser != STATUS_OK |-> rsp_tdata == '0, "error result with nonzero value")

   // input back-pressure only comes from a stalled output
   `BGI_ASSERT(a_stall_src, !req_tready |-> rsp_tvalid && !rsp_tready, "request stalled with output free")

   // pipeline empty right after reset
   `BGI_ASSERT_ALWAYS(a_reset_empty, reset |=> !rsp_tvalid, "result present after reset")

endmodule

bind bilinear_grid_interpolator bilinear_grid_interpolator_checker u_checker (.*);

`default_nettype wire

// ===== verif/bilinear_grid_interpolator_tb.sv =====
`timescale 1ns / 1ps
`default_nettype none

module bilinear_grid_interpolator_tb;
   import bgi_pkg::*;

   localparam int NPTS_MAX = 64;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } result_type;

   typedef struct {
      logic        mode;
      logic [5:0]  xi;
      logic [5:0]  yi;
      logic [31:0] gval;
      logic [31:0] xc;
      logic [31:0] yc;
      logic        has_exp;   // expected result typed into the row
      result_type  exp_res;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic [1:0] rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [2:0] csr_index = '0;
   logic [31:0] csr_data = '0;

   bilinear_grid_interpolator u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow of the block's registers and grid
   logic signed [31:0] lim_xlo, lim_xhi, lim_ylo, lim_yhi;
   logic [31:0] step_x, step_y;
   logic [6:0]  npx_reg, npy_reg;
   logic signed [63:0] samples [NPTS_MAX*NPTS_MAX];
   bit grid_ok;

   result_type expected_q[$];
   int errors = 0;
   int words_in = 0, words_out = 0, evals_ok = 0, evals_oor = 0, evals_nogrid = 0;
   int idle_cycles = 0;
   int stall_left = 0;
   bit sim_done = 1'b0;

   function automatic int eff_points(logic [6:0] n);
      if (n < 2) return 2;
      if (n > NPTS_MAX) return NPTS_MAX;
      return n;
   endfunction

   // cell index and 17-bit fraction along one axis
   function automatic void find_cell(logic signed [63:0] off, logic [31:0] sc, int np,
                                     output int idx, output logic [16:0] frac);
      logic [63:0] u;
      logic [63:0] c;
      u = off * {32'd0, sc};
      c = u >> 32;
      if (c >= np - 1) begin
         idx = np - 2;
         frac = 17'h10000;
      end else begin
         idx = int'(c);
         frac = {1'b0, u[31:16]};
      end
   endfunction

   function automatic logic signed [63:0] blend(logic signed [63:0] a, logic signed [63:0] b,
                                                logic [16:0] frac);
      logic signed [63:0] p;
      p = (b - a) * $signed({47'd0, frac}) + 64'sd32768;
      return a + (p >>> 16);
   endfunction

   function automatic result_type interp_point(logic mode, logic [5:0] xi, logic [5:0] yi,
                                               logic [31:0] gval, logic [31:0] xc,
                                               logic [31:0] yc);
      result_type r;
      int nx, ny, ci, cj;
      logic [16:0] fx, fy;
      logic signed [63:0] c0, c1, v, x, y;
      nx = eff_points(npx_reg);
      ny = eff_points(npy_reg);
      r.value = '0;
      r.status = STATUS_OK;
      if (mode == MODE_WRITE) begin
         if (xi < nx && yi < ny) begin
            samples[xi*NPTS_MAX + yi] = $signed(gval);
            if (xi == nx - 1 && yi == ny - 1) grid_ok = 1'b1;
         end
      end else begin
         x = $signed(xc);
         y = $signed(yc);
         if (x > lim_xhi || x < lim_xlo || y > lim_yhi || y < lim_ylo) begin
            r.status = STATUS_OUT_OF_RANGE;
         end else if (!grid_ok) begin
            r.status = STATUS_NO_GRID;
         end else begin
            find_cell(x - lim_xlo, step_x, nx, ci, fx);
            find_cell(y - lim_ylo, step_y, ny, cj, fy);
            c0 = blend(samples[ci*NPTS_MAX+cj], samples[ci*NPTS_MAX+cj+1], fy);
            c1 = blend(samples[(ci+1)*NPTS_MAX+cj], samples[(ci+1)*NPTS_MAX+cj+1], fy);
            v = blend(c0, c1, fx);
            if (v > 64'sd2147483647) v = 64'sd2147483647;
            if (v < -64'sd2147483648) v = -64'sd2147483648;
            r.value = v[31:0];
         end
      end
      return r;
   endfunction

   // result checker and watchdog
   always @(posedge clock) begin
      result_type got, want;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_valid)
            idle_cycles <= 0;
         else
            idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT && !sim_done) begin
            $display("%0t watchdog: no progress", $time);
            $display("simulation failed");
            $finish;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.value = rsp_tdata;
            got.status = rsp_tuser;
            words_out <= words_out + 1;
            if (expected_q.size() == 0) begin
               $display("%0t unexpected word value=%h status=%0d", $time, got.value,
                        got.status);
               errors++;
            end else begin
               want = expected_q.pop_front();
               if (got.value !== want.value) begin
                  $display("%0t value mismatch: expected %h actual %h", $time, want.value,
                           got.value);
                  errors++;
               end
               if (got.status !== want.status) begin
                  $display("%0t status mismatch: expected %0d actual %0d", $time,
                           want.status, got.status);
                  errors++;
               end
            end
         end
      end
   end

   // random back-pressure: mostly short stalls, an occasional long one
   always @(posedge clock) begin
      int r;
      r = $urandom_range(0, 99);
      if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (r < 2) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(10, 40);
      end else begin
         rsp_tready <= (r < 65);
      end
   end

   task automatic send_word(logic mode, logic [5:0] xi, logic [5:0] yi, logic [31:0] gval,
                            logic [31:0] xc, logic [31:0] yc, bit has_exp,
                            result_type exp_res);
      result_type pred;
      int gap;
      // sender gap: usually none or short, sometimes long
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 49) == 0) gap = $urandom_range(10, 30);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      pred = interp_point(mode, xi, yi, gval, xc, yc);
      if (has_exp && pred !== exp_res) begin
         $display("%0t table row disagrees with prediction: expected %h actual %h", $time,
                  exp_res, pred);
         errors++;
      end
      expected_q = {expected_q, pred};
      if (mode == MODE_EVAL) begin
         if (pred.status == STATUS_OK) evals_ok++;
         else if (pred.status == STATUS_OUT_OF_RANGE) evals_oor++;
         else evals_nogrid++;
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tdata <= {4'd0, yc, xc, gval, yi, xi};
      words_in++;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain_pipe();
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         REG_X_MIN:    lim_xlo = val;
         REG_X_MAX:    lim_xhi = val;
         REG_X_SCALE:  step_x = val;
         REG_Y_MIN:    lim_ylo = val;
         REG_Y_MAX:    lim_yhi = val;
         REG_Y_SCALE:  step_y = val;
         REG_X_POINTS: npx_reg = val[6:0];
         REG_Y_POINTS: npy_reg = val[6:0];
         default: ;
      endcase
   endtask

   // fills every node in use so no read of an unwritten sample can happen
   task automatic fill_grid(int kind);
      int nx, ny;
      logic [31:0] v;
      nx = eff_points(npx_reg);
      ny = eff_points(npy_reg);
      for (int i = 0; i < nx; i++)
         for (int j = 0; j < ny; j++) begin
            if (kind == 0) v = $urandom;
            else if (kind == 1) v = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            else v = $signed($urandom_range(0, 2000000)) - 1000000;
            if (!(i == nx - 1 && j == ny - 1))
               send_word(MODE_WRITE, 6'(i), 6'(j), v, $urandom, $urandom, 1'b0, '0);
         end
      send_word(MODE_WRITE, 6'(nx - 1), 6'(ny - 1), $urandom, $urandom, $urandom, 1'b0,
                '0);
   endtask

   function automatic logic [31:0] rand_coord(logic signed [31:0] lo, logic signed [31:0] hi);
      logic signed [63:0] span;
      int r;
      r = $urandom_range(0, 19);
      if (r == 0) return lo;
      if (r == 1) return hi;
      if (r == 2) return $urandom;
      if (r == 3) return lo - 1;
      if (r == 4) return hi + 1;
      span = hi - lo;
      if (span < 0) return $urandom;
      return lo + (({$urandom, $urandom} & 64'h00000000ffffffff) * span >> 32);
   endfunction

   // one random grid setting; returns after writing the registers
   task automatic random_setting(int phase);
      logic signed [31:0] lo, hi;
      logic [31:0] span;
      int nx, ny;
      nx = (phase % 7 == 6) ? $urandom_range(40, 64) : $urandom_range(2, 6);
      ny = (phase % 7 == 5) ? $urandom_range(40, 64) : $urandom_range(2, 6);
      lo = $signed($urandom_range(0, 400000)) - 200000;
      span = $urandom_range(1, 600000);
      hi = lo + span;
      write_reg(REG_X_MIN, lo);
      write_reg(REG_X_MAX, hi);
      // a correct reciprocal most of the time, sometimes a wild one
      write_reg(REG_X_SCALE, ($urandom_range(0, 4) == 0) ? $urandom
                             : 32'((64'(nx - 1) << 32) / span));
      lo = $signed($urandom_range(0, 400000)) - 200000;
      span = $urandom_range(1, 600000);
      hi = lo + span;
      write_reg(REG_Y_MIN, lo);
      write_reg(REG_Y_MAX, hi);
      write_reg(REG_Y_SCALE, ($urandom_range(0, 4) == 0) ? $urandom
                             : 32'((64'(ny - 1) << 32) / span));
      write_reg(REG_X_POINTS, nx);
      write_reg(REG_Y_POINTS, ny);
   endtask

   stim_row_type dir_rows[$];

   function automatic stim_row_type row(logic m, logic [5:0] xi, logic [5:0] yi,
                                        logic [31:0] g, logic [31:0] xc, logic [31:0] yc,
                                        bit he, logic [31:0] ev, logic [1:0] es);
      stim_row_type r;
      r.mode = m; r.xi = xi; r.yi = yi; r.gval = g; r.xc = xc; r.yc = yc;
      r.has_exp = he; r.exp_res.value = ev; r.exp_res.status = es;
      return r;
   endfunction

   initial begin
      lim_xlo = 0; lim_xhi = 32'h10000; step_x = 32'h10000;
      lim_ylo = 0; lim_yhi = 32'h10000; step_y = 32'h10000;
      npx_reg = 2; npy_reg = 2;
      grid_ok = 1'b0;
      foreach (samples[k]) begin
         samples[k] = 0;
      end
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table on the reset 2x2 unit grid
      // no grid yet, in-range point
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 32'h8000, 32'h8000, 1, 0, STATUS_NO_GRID)};
      // outside limits wins over missing grid
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 32'h10001, 0, 1, 0, STATUS_OUT_OF_RANGE)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 0, 32'hffffffff, 1, 0, STATUS_OUT_OF_RANGE)};
      dir_rows = {dir_rows, row(MODE_EVAL, 0, 0, 0, 32'h80000000, 32'h7fffffff, 1, 0,
                                STATUS_OUT_OF_RANGE)};
      // writes outside points in use are ignored, corner (63,63) included
      dir_rows = {dir_rows,
                  row(MODE_WRITE, 63, 63, 32'hdeadbeef, '1, '1, 1, 0, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_WRITE, 2, 1, 32'h12345678, 0, 0, 1, 0, STATUS_OK)};
      dir_rows = {dir_rows, row(MODE_EVAL, 0, 0, 0, 0, 0, 1, 0, STATUS_NO_GRID)};
      dir_rows = {dir_rows,
                  row(MODE_WRITE, 0, 0, 32'h7fffffff, 0, 0, 1, 0, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_WRITE, 0, 1, 32'h80000000, 0, 0, 1, 0, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_WRITE, 1, 0, 32'h80000000, 0, 0, 1, 0, STATUS_OK)};
      // far corner marks the grid ready
      dir_rows = {dir_rows,
                  row(MODE_WRITE, 1, 1, 32'h7fffffff, 0, 0, 1, 0, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 0, 0, 1, 32'h7fffffff, STATUS_OK)};
      // upper limit itself lands on the last cell with full fraction
      dir_rows = {dir_rows, row(MODE_EVAL, 0, 0, 0, 32'h10000, 32'h10000, 1, 32'h7fffffff,
                                STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 32'h10000, 0, 1, 32'h80000000, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 0, 32'h10000, 1, 32'h80000000, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 32'h8000, 32'h8000, 0, 0, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 32'h0001, 32'hffff, 0, 0, STATUS_OK)};
      dir_rows = {dir_rows,
                  row(MODE_EVAL, 0, 0, 0, 32'hc000, 32'h4000, 0, 0, STATUS_OK)};
      foreach (dir_rows[k])
         send_word(dir_rows[k].mode, dir_rows[k].xi, dir_rows[k].yi, dir_rows[k].gval,
                   dir_rows[k].xc, dir_rows[k].yc, dir_rows[k].has_exp, dir_rows[k].exp_res);
      drain_pipe();

      // extremes: full range limits, max x scale, zero y scale, points clamped from 0 and 127
      write_reg(REG_X_MIN, 32'h80000000);
      write_reg(REG_X_MAX, 32'h7fffffff);
      write_reg(REG_X_SCALE, 32'hffffffff);
      write_reg(REG_Y_MIN, 32'h80000000);
      write_reg(REG_Y_MAX, 32'h7fffffff);
      write_reg(REG_Y_SCALE, 32'h00000000);
      write_reg(REG_X_POINTS, 7'd0);
      write_reg(REG_Y_POINTS, 7'd127);
      fill_grid(1);
      for (int k = 0; k < 20; k++)
         send_word(MODE_EVAL, 6'($urandom), 6'($urandom), $urandom,
                   rand_coord(lim_xlo, lim_xhi), rand_coord(lim_ylo, lim_yhi), 1'b0, '0);
      drain_pipe();

      // inverted limits: every point out of range
      write_reg(REG_X_POINTS, 7'd2);
      write_reg(REG_Y_POINTS, 7'd2);
      write_reg(REG_X_MIN, 32'h00010000);
      write_reg(REG_X_MAX, 32'h00000000);
      for (int k = 0; k < 8; k++)
         send_word(MODE_EVAL, 0, 0, 0, $urandom, $urandom, 1'b0, '0);
      drain_pipe();

      // random phases: well-formed grid loads followed by evaluations
      for (int phase = 0; words_in < 1100; phase++) begin
         random_setting(phase);
         fill_grid(phase % 3);
         for (int k = 0; k < 60; k++) begin
            if ($urandom_range(0, 9) == 0)
               // overwrite a node in use, or a stray write outside the grid
               send_word(MODE_WRITE, 6'($urandom_range(0, eff_points(npx_reg) - 1 +
                         ($urandom_range(0, 3) == 0 ? 8 : 0))),
                         6'($urandom_range(0, eff_points(npy_reg) - 1)), $urandom,
                         $urandom, $urandom, 1'b0, '0);
            else
               send_word(MODE_EVAL, 6'($urandom), 6'($urandom), $urandom,
                         rand_coord(lim_xlo, lim_xhi), rand_coord(lim_ylo, lim_yhi),
                         1'b0, '0);
         end
         drain_pipe();
      end

      sim_done = 1'b1;
      $display("covered %0d words in, %0d out: %0d ok, %0d out of range, %0d no-grid evals",
               words_in, words_out, evals_ok, evals_oor, evals_nogrid);
      $display("register settings swept incl. full-range limits, clamped points, wild scales");
      if (errors == 0 && expected_q.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

`default_nettype wire
